FILE: rtl/bs1d_pkg.sv
// Package for the 1D blend space segment weight block.
// Types and constants shared by the front, back and top level. No dependencies.
package bs1d_pkg;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_EVAL   = 1'b1;

  localparam logic signed [33:0] MIN_RANGE    = 34'sd6;
  localparam logic [30:0]        MIN_DURATION = 31'd6;
  localparam logic [31:0]        ONE_Q16      = 32'd65536;

  // job handed from front to back
  typedef struct packed {
    logic        eval;       // 1: arithmetic needed, 0: pass status only
    logic        single;     // single entry table
    logic [1:0]  status;
    logic [7:0]  clip_a;
    logic [7:0]  clip_b;
    logic        two;
    logic        do_weight;  // bracketing pair with a wide range
    logic [47:0] w_num;      // (param - lower) << 16
    logic [32:0] w_den;      // range
    logic [30:0] dur_a;
    logic [30:0] dur_b;
    logic [31:0] play_time;
  } job_t;

  typedef enum logic [2:0] {
    F_IDLE, F_SCAN, F_SHIFT, F_EMIT
  } front_state_t;

  typedef enum logic [3:0] {
    B_IDLE, B_WDIV, B_BLEND, B_BDIV, B_REM, B_MUL1, B_DIV1, B_MUL2, B_DIV2, B_DONE
  } back_state_t;

endpackage

FILE: rtl/blend_space_1d_segment_weight_core.sv
// Top level of the 1D blend space segment weight block.
// Depends on bs1d_pkg, bs1d_front, bs1d_back, bs1d_divider.
//
//  channel | handshake    | ports
//  input   | push / full  | operation clip_id clip_duration clip_threshold play_time blend_param
//  result  | empty / pop  | status first_clip second_clip blend_weight first_time second_time
//          |              | two_clips
//
// An insert runs the table scan, then shifts one entry a cycle to open the slot.
// An evaluate takes the table scan plus up to four passes of the shared 64 bit
// restoring divider at one bit a cycle.
// Reset (rst, synchronous) empties the table; entries hold no reset value.
// A held result stalls the back; the front takes at most one more item and holds its job.
module blend_space_1d_segment_weight_core import bs1d_pkg::*; #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        operation,
  input  logic [7:0]  clip_id,
  input  logic [30:0] clip_duration,
  input  logic [31:0] clip_threshold,
  input  logic [31:0] play_time,
  input  logic [31:0] blend_param,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  status,
  output logic [7:0]  first_clip,
  output logic [7:0]  second_clip,
  output logic [16:0] blend_weight,
  output logic [31:0] first_time,
  output logic [31:0] second_time,
  output logic        two_clips
);

  job_t job;
  logic job_valid, job_ready;

  bs1d_front #(.MAX_ENTRIES(MAX_ENTRIES)) u_front (
    .clk, .rst, .push, .full, .operation, .clip_id, .clip_duration,
    .clip_threshold, .play_time, .blend_param, .job_valid, .job_ready, .job
  );

  bs1d_back u_back (
    .clk, .rst, .job_valid, .job_ready, .job, .empty, .pop, .status,
    .first_clip, .second_clip, .blend_weight, .first_time, .second_time, .two_clips
  );

endmodule

FILE: rtl/bs1d_divider.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Uses bs1d_pkg only for style consistency of imports.
module bs1d_divider import bs1d_pkg::*; #(
  parameter int W = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient,
  output logic [W-1:0] remainder
);

  localparam int CW = $clog2(W + 1);

  logic [W-1:0] quo;
  logic [W-1:0] rem;
  logic [W-1:0] dvs;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [W:0]    trial;

  assign trial = {rem, quo[W-1]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      if (!trial[W]) begin
        rem <= trial[W-1:0];
        quo <= {quo[W-2:0], 1'b1};
      end else begin
        rem <= {rem[W-2:0], quo[W-1]};
        quo <= {quo[W-2:0], 1'b0};
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

FILE: rtl/bs1d_front.sv
// Front: holds the sorted entry table, performs inserts and the bracket search.
// Depends on bs1d_pkg.
module bs1d_front import bs1d_pkg::*; #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        operation,
  input  logic [7:0]  clip_id,
  input  logic [30:0] clip_duration,
  input  logic [31:0] clip_threshold,
  input  logic [31:0] play_time,
  input  logic [31:0] blend_param,
  output logic        job_valid,
  input  logic        job_ready,
  output job_t        job
);

  localparam int IW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);

  logic [31:0] thr_mem [MAX_ENTRIES];
  logic [30:0] dur_mem [MAX_ENTRIES];
  logic [7:0]  id_mem  [MAX_ENTRIES];

  front_state_t state, state_next;
  logic [CW-1:0] count;
  logic [CW-1:0] idx;
  logic          op_r;
  logic [7:0]    id_r;
  logic [30:0]   dur_r;
  logic [31:0]   thr_r;
  logic [31:0]   time_r;
  logic [31:0]   par_r;
  logic          drop;     // insert into a full table

  // registered table reads
  logic [31:0] rd_thr;
  logic [30:0] rd_dur;
  logic [7:0]  rd_id;
  logic        rd_ok;
  logic        sh_ok;      // rd_* holds the entry at idx, due one slot up, during a shift
  logic [31:0] prev_thr;
  logic [30:0] prev_dur;
  logic [7:0]  prev_id;

  logic [IW-1:0] rd_addr;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [31:0]   wr_thr;
  logic [30:0]   wr_dur;
  logic [7:0]    wr_id;

  logic [CW-1:0] pos;      // insert position
  logic          found;
  job_t          job_r;
  logic          job_v;

  // shift reads the entry below idx; scan reads idx
  assign rd_addr = (state == F_SHIFT && idx != pos) ? IW'(idx - 1'b1) : idx[IW-1:0];
  assign full    = (state != F_IDLE) || job_v;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      thr_mem[wr_addr] <= wr_thr;
      dur_mem[wr_addr] <= wr_dur;
      id_mem[wr_addr]  <= wr_id;
    end
    rd_thr <= thr_mem[rd_addr];
    rd_dur <= dur_mem[rd_addr];
    rd_id  <= id_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      count <= '0;
      job_v <= 1'b0;
      rd_ok <= 1'b0;
      sh_ok <= 1'b0;
    end else begin
      state <= state_next;
      if (job_v && job_ready) job_v <= 1'b0;
      if (state == F_EMIT) job_v <= 1'b1;
      if (state == F_SHIFT && idx == pos && !sh_ok) count <= count + 1'b1;
      rd_ok <= (state == F_SCAN) && (idx < count);
      sh_ok <= (state == F_SHIFT) && (idx != pos);
    end
  end

  // scan: idx walks up issuing reads; the registered data in rd_* is for idx-1
  logic [CW-1:0] ridx;   // index of entry now in rd_*
  logic signed [32:0] sp, sthr, sprev;
  assign sp    = {par_r[31], par_r};
  assign sthr  = {rd_thr[31], rd_thr};
  assign sprev = {prev_thr[31], prev_thr};

  always_ff @(posedge clk) begin
    if (state == F_IDLE && push && !full) begin
      op_r   <= operation;
      id_r   <= clip_id;
      dur_r  <= clip_duration;
      thr_r  <= clip_threshold;
      time_r <= play_time;
      par_r  <= blend_param;
      drop   <= (count == CW'(MAX_ENTRIES));
      idx    <= '0;
      ridx   <= '0;
      found  <= 1'b0;
      pos    <= count;
      job_r  <= '0;
    end else if (state == F_SCAN) begin
      if (idx < count) idx <= idx + 1'b1;
      if (rd_ok) begin
        ridx     <= ridx + 1'b1;
        prev_thr <= rd_thr;
        prev_dur <= rd_dur;
        prev_id  <= rd_id;
        if (op_r == OP_INSERT) begin
          if (!found && $signed(rd_thr) > $signed(thr_r)) begin
            found <= 1'b1;
            pos   <= ridx;
          end
        end else if (!found) begin
          if (count == CW'(1)) begin
            found <= 1'b1;
            job_r.single <= 1'b1;
            job_r.clip_a <= rd_id;
            job_r.clip_b <= rd_id;
            job_r.dur_a  <= rd_dur;
          end else if (ridx == '0) begin
            if (sp <= sthr) begin
              found <= 1'b1;
              job_r.clip_a <= rd_id;
              job_r.clip_b <= rd_id;
              job_r.dur_a  <= rd_dur;
              job_r.dur_b  <= rd_dur;
            end
          end else if (ridx == count - 1'b1 && sp >= sthr) begin
            // at or above the last threshold: last entry on both sides
            found <= 1'b1;
            job_r.clip_a <= rd_id;
            job_r.clip_b <= rd_id;
            job_r.dur_a  <= rd_dur;
            job_r.dur_b  <= rd_dur;
          end else if (sp <= sthr) begin
            found <= 1'b1;
            job_r.clip_a <= prev_id;
            job_r.clip_b <= rd_id;
            job_r.dur_a  <= prev_dur;
            job_r.dur_b  <= rd_dur;
            job_r.two    <= 1'b1;
            job_r.do_weight <= (sthr - sprev) > MIN_RANGE[32:0];
            job_r.w_num  <= {32'(sp - sprev), 16'd0};
            job_r.w_den  <= 33'(sthr - sprev);
          end
        end
      end
    end else if (state == F_SHIFT) begin
      if (idx != pos) idx <= idx - 1'b1;
    end else if (state == F_EMIT) begin
      job_r.eval      <= (op_r == OP_EVAL) && (count != '0);
      job_r.play_time <= time_r;
      if (op_r == OP_INSERT)
        job_r.status <= drop ? STATUS_FULL : STATUS_OK;
      else
        job_r.status <= (count == '0) ? STATUS_EMPTY : STATUS_OK;
    end
  end

  // (param - lower) is in 0..range < 2^32, so its Q16 shift fits 48 bits and
  // param - lower <= range bounds the weight quotient by 65536.
  logic done_scan;
  assign done_scan = (idx == count) && !rd_ok;

  always_comb begin
    state_next = state;
    wr_en   = 1'b0;
    wr_addr = idx[IW-1:0];
    wr_thr  = rd_thr;
    wr_dur  = rd_dur;
    wr_id   = rd_id;
    case (state)
      F_IDLE: begin
        if (push && !full) state_next = F_SCAN;
      end
      F_SCAN: begin
        if (done_scan) begin
          if (op_r == OP_INSERT && count != CW'(MAX_ENTRIES)) state_next = F_SHIFT;
          else state_next = F_EMIT;
        end
      end
      F_SHIFT: begin
        // idx walks down from count; the entry read below idx is registered in rd_*
        // and then written one slot up; last, the new entry is written at pos
        if (sh_ok) begin
          wr_en   = 1'b1;
          wr_addr = IW'(idx + 1'b1);
        end else if (idx == pos) begin
          wr_en  = 1'b1;
          wr_thr = thr_r;
          wr_dur = dur_r;
          wr_id  = id_r;
          state_next = F_EMIT;
        end
      end
      F_EMIT: state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  assign job_valid = job_v;
  assign job       = job_r;

endmodule

FILE: rtl/bs1d_back.sv
// Back: weight division, duration blend, phase remainder and sample times.
// Depends on bs1d_pkg and bs1d_divider.
module bs1d_back import bs1d_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        job_valid,
  output logic        job_ready,
  input  job_t        job,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  status,
  output logic [7:0]  first_clip,
  output logic [7:0]  second_clip,
  output logic [16:0] blend_weight,
  output logic [31:0] first_time,
  output logic [31:0] second_time,
  output logic        two_clips
);

  back_state_t state, state_next;
  job_t        j;
  logic [16:0] w;
  logic [31:0] da, db, bd;
  logic [31:0] rem_mag;
  logic        neg;
  logic [63:0] prod;
  logic [31:0] t1;
  logic        out_v;

  logic        d_start, d_done;
  logic [63:0] d_num, d_den, d_q, d_r;

  bs1d_divider #(.W(64)) u_div (
    .clk, .rst, .start(d_start), .dividend(d_num), .divisor(d_den),
    .done(d_done), .quotient(d_q), .remainder(d_r)
  );

  logic [31:0] tmag;
  assign tmag = j.play_time[31] ? (~j.play_time + 1'b1) : j.play_time;

  assign job_ready = (state == B_IDLE) && !out_v;
  assign empty     = !out_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      out_v <= 1'b0;
    end else begin
      state <= state_next;
      if (pop && out_v) out_v <= 1'b0;
      else if (state == B_DONE && state_next == B_IDLE) out_v <= 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    d_start = 1'b0;
    d_num   = '0;
    d_den   = 64'd1;
    case (state)
      B_IDLE: if (job_valid && job_ready) state_next = B_WDIV;
      B_WDIV: begin
        if (!j.eval) state_next = B_DONE;
        else if (j.single) begin
          if (j.dur_a == '0) state_next = B_DONE;
          else begin
            d_start = 1'b1; d_num = {32'd0, tmag}; d_den = {33'd0, j.dur_a};
            state_next = B_REM;
          end
        end else if (j.do_weight) begin
          d_start = 1'b1; d_num = {16'd0, j.w_num}; d_den = {31'd0, j.w_den};
          state_next = B_BLEND;
        end else state_next = B_BLEND;
      end
      B_BLEND: if (!j.do_weight || d_done) state_next = B_BDIV;
      B_BDIV: begin
        d_start = 1'b1; d_num = {32'd0, tmag}; d_den = {32'd0, bd};
        state_next = B_REM;
      end
      B_REM: if (d_done) state_next = j.single ? B_DONE : B_MUL1;
      B_MUL1: state_next = B_DIV1;
      B_DIV1: begin
        d_start = 1'b1; d_num = prod; d_den = {32'd0, bd};
        state_next = B_MUL2;
      end
      B_MUL2: if (d_done) state_next = B_DIV2;
      B_DIV2: begin
        d_start = 1'b1; d_num = prod; d_den = {32'd0, bd};
        state_next = B_DONE;
      end
      B_DONE: state_next = (!j.eval || j.single) ? B_IDLE : (d_done ? B_IDLE : B_DONE);
      default: state_next = B_IDLE;
    endcase
  end

  // blended duration
  logic [48:0] mix;
  assign mix = da * (ONE_Q16[16:0] - w) + db * w;

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        if (job_valid && job_ready) begin
          j <= job;
          w <= '0;
          first_time  <= '0;
          second_time <= '0;
        end
      end
      B_WDIV: begin
        da <= (j.dur_a <= MIN_DURATION) ? ONE_Q16 : {1'b0, j.dur_a};
        db <= (j.dur_b <= MIN_DURATION) ? ONE_Q16 : {1'b0, j.dur_b};
      end
      B_BLEND: begin
        if (j.do_weight && d_done) w <= d_q[16:0];
      end
      B_REM: begin
        if (d_done) begin
          rem_mag <= d_r[31:0];
          neg     <= j.play_time[31];
          if (j.single) begin
            first_time  <= j.play_time[31] ? (~d_r[31:0] + 1'b1) : d_r[31:0];
            second_time <= j.play_time[31] ? (~d_r[31:0] + 1'b1) : d_r[31:0];
          end
        end
      end
      B_MUL1: prod <= rem_mag * da;
      B_MUL2: begin
        if (d_done) begin
          t1   <= d_q[31:0];
          prod <= rem_mag * db;
        end
      end
      B_DONE: begin
        if (j.eval && !j.single && d_done) begin
          first_time  <= neg ? (~t1 + 1'b1) : t1;
          second_time <= neg ? (~d_q[31:0] + 1'b1) : d_q[31:0];
        end
      end
      default: ;
    endcase
    // with no weight division w is 0 and mix reduces to da << 16
    if (state == B_BLEND && state_next == B_BDIV) begin
      if (j.do_weight) bd <= 32'(((49'(da) * (49'(ONE_Q16) - 49'(d_q[16:0])))
                                 + 49'(db) * 49'(d_q[16:0])) >> 16);
      else bd <= 32'(mix >> 16);
    end
  end

  assign status       = j.status;
  assign first_clip   = j.eval ? j.clip_a : 8'd0;
  assign second_clip  = j.eval ? j.clip_b : 8'd0;
  assign blend_weight = w;
  assign two_clips    = j.eval & j.two;

endmodule

FILE: bench/blend_space_1d_segment_weight_checker.sv
// Checker for the 1D blend space segment weight core: predicts each result
// from accepted input transactions and compares it with the result channel.
// Depends on bs1d_pkg.
`timescale 1ns / 100ps

module blend_space_1d_segment_weight_checker import bs1d_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        full,
  input  logic        operation,
  input  logic [7:0]  clip_id,
  input  logic [30:0] clip_duration,
  input  logic [31:0] clip_threshold,
  input  logic [31:0] play_time,
  input  logic [31:0] blend_param,
  input  logic        empty,
  input  logic        pop,
  input  logic [1:0]  status,
  input  logic [7:0]  first_clip,
  input  logic [7:0]  second_clip,
  input  logic [16:0] blend_weight,
  input  logic [31:0] first_time,
  input  logic [31:0] second_time,
  input  logic        two_clips,
  output int          failures,
  output int          pending
);

  localparam int TABLE_DEPTH = 16;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  first_clip;
    logic [7:0]  second_clip;
    logic [16:0] weight;
    logic [31:0] first_time;
    logic [31:0] second_time;
    logic        two_clips;
  } blend_result_t;

  logic signed [31:0] tbl_thr [TABLE_DEPTH];
  logic [30:0]        tbl_dur [TABLE_DEPTH];
  logic [7:0]         tbl_id  [TABLE_DEPTH];
  int                 tbl_count;

  blend_result_t blend_queue[$];

  function automatic longint eff_duration(logic [30:0] d);
    return (d <= MIN_DURATION) ? 64'sd65536 : longint'(d);
  endfunction

  // updates the table copy for inserts, returns the expected result
  task automatic compute_blend(output blend_result_t r);
    int pos, a, b;
    longint t, p, w, da, db, bd, rem, rng;
    r = '0;
    if (operation == OP_INSERT) begin
      if (tbl_count >= TABLE_DEPTH) begin
        r.status = STATUS_FULL;
        return;
      end
      pos = 0;
      while (pos < tbl_count && tbl_thr[pos] <= $signed(clip_threshold)) pos++;
      for (int k = tbl_count; k > pos; k--) begin
        tbl_thr[k] = tbl_thr[k-1];
        tbl_dur[k] = tbl_dur[k-1];
        tbl_id[k]  = tbl_id[k-1];
      end
      tbl_thr[pos] = clip_threshold;
      tbl_dur[pos] = clip_duration;
      tbl_id[pos]  = clip_id;
      tbl_count++;
      r.status = STATUS_OK;
      return;
    end
    if (tbl_count == 0) begin
      r.status = STATUS_EMPTY;
      return;
    end
    t = longint'($signed(play_time));
    p = longint'($signed(blend_param));
    r.status = STATUS_OK;
    if (tbl_count == 1) begin
      rem = (tbl_dur[0] > 0) ? t % longint'(tbl_dur[0]) : 0;
      r.first_clip  = tbl_id[0];
      r.second_clip = tbl_id[0];
      r.first_time  = rem[31:0];
      r.second_time = rem[31:0];
      return;
    end
    w = 0;
    a = 0;
    b = 0;
    if (p <= tbl_thr[0]) begin
      a = 0;
      b = 0;
    end else if (p >= tbl_thr[tbl_count-1]) begin
      a = tbl_count - 1;
      b = a;
    end else begin
      for (int k = 0; k + 1 < tbl_count; k++) begin
        if (p >= tbl_thr[k] && p <= tbl_thr[k+1]) begin
          rng = longint'(tbl_thr[k+1]) - longint'(tbl_thr[k]);
          a = k;
          b = k + 1;
          // narrow bracket: distinct clips, zero weight
          if (rng > 6) w = ((p - longint'(tbl_thr[k])) * 65536) / rng;
          break;
        end
      end
    end
    da = eff_duration(tbl_dur[a]);
    db = eff_duration(tbl_dur[b]);
    bd = (da * (65536 - w) + db * w) / 65536;
    if (bd <= 0) bd = 1;
    rem = t % bd;
    r.first_clip  = tbl_id[a];
    r.second_clip = tbl_id[b];
    r.weight      = w[16:0];
    r.first_time  = 32'((rem * da) / bd);
    r.second_time = 32'((rem * db) / bd);
    r.two_clips   = (a != b);
  endtask

  always @(posedge clk) begin
    blend_result_t exp_r;
    if (rst) begin
      tbl_count = 0;
      failures  = 0;
      blend_queue.delete();
    end else begin
      if (pop && !empty) begin
        if (blend_queue.size() == 0) begin
          $error("result transaction with nothing expected");
          failures++;
        end else begin
          exp_r = blend_queue.pop_front();
          if (status !== exp_r.status) begin
            $error("status exp %0d got %0d", exp_r.status, status); failures++;
          end
          if (first_clip !== exp_r.first_clip) begin
            $error("first_clip exp %0d got %0d", exp_r.first_clip, first_clip); failures++;
          end
          if (second_clip !== exp_r.second_clip) begin
            $error("second_clip exp %0d got %0d", exp_r.second_clip, second_clip);
            failures++;
          end
          if (blend_weight !== exp_r.weight) begin
            $error("blend_weight exp %0d got %0d", exp_r.weight, blend_weight); failures++;
          end
          if (first_time !== exp_r.first_time) begin
            $error("first_time exp %h got %h", exp_r.first_time, first_time); failures++;
          end
          if (second_time !== exp_r.second_time) begin
            $error("second_time exp %h got %h", exp_r.second_time, second_time);
            failures++;
          end
          if (two_clips !== exp_r.two_clips) begin
            $error("two_clips exp %0d got %0d", exp_r.two_clips, two_clips); failures++;
          end
        end
      end
      if (push && !full) begin
        compute_blend(exp_r);
        blend_queue.push_back(exp_r);
      end
    end
    pending = blend_queue.size();
  end

endmodule

FILE: bench/tb_blend_space_1d_segment_weight_core.sv
// Testbench top for blend_space_1d_segment_weight_core: drives insert and
// evaluate transactions, random pop stalls, and reports the verdict.
// Depends on bs1d_pkg, the core and blend_space_1d_segment_weight_checker.
`timescale 1ns / 100ps

module tb_blend_space_1d_segment_weight_core import bs1d_pkg::*; ();

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic        operation = OP_INSERT;
  logic [7:0]  clip_id = '0;
  logic [30:0] clip_duration = '0;
  logic [31:0] clip_threshold = '0;
  logic [31:0] play_time = '0;
  logic [31:0] blend_param = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [1:0]  status;
  logic [7:0]  first_clip, second_clip;
  logic [16:0] blend_weight;
  logic [31:0] first_time, second_time;
  logic        two_clips;
  int          failures, pending;

  // thresholds placed in the table, used to aim blend parameters
  logic [31:0] thr_list [16];
  int          thr_used = 0;
  bit          pop_free = 1'b0;   // stretch with no result stalls

  always #5 clk = ~clk;

  blend_space_1d_segment_weight_core dut (.*);

  blend_space_1d_segment_weight_checker chk (.*);

  // short gap usually, long one now and then
  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 93) return $urandom_range(1, 4);
    return $urandom_range(20, 120);
  endfunction

  // one transaction: fields set at the falling edge, held until accepted
  task automatic send_item(input logic op, input logic [7:0] id, input logic [30:0] dur,
                           input logic [31:0] thr, input logic [31:0] pt,
                           input logic [31:0] bp);
    operation      <= op;
    clip_id        <= id;
    clip_duration  <= dur;
    clip_threshold <= thr;
    play_time      <= pt;
    blend_param    <= bp;
    push           <= 1'b1;
    do @(posedge clk); while (full);
    @(negedge clk);
  endtask

  task automatic idle_sender(input int n);
    if (n > 0) begin
      push <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic add_entry(input logic [7:0] id, input logic [30:0] dur,
                           input logic [31:0] thr);
    send_item(OP_INSERT, id, dur, thr, $urandom(), $urandom());
    if (thr_used < 16) begin
      thr_list[thr_used] = thr;
      thr_used++;
    end
  endtask

  // blend parameter near a stored threshold, between two, or anywhere
  function automatic logic [31:0] aim_param();
    int sel;
    logic [31:0] x, y;
    sel = $urandom_range(0, 9);
    x = thr_list[$urandom_range(0, thr_used - 1)];
    y = thr_list[$urandom_range(0, thr_used - 1)];
    case (sel)
      0, 1, 2: return x + 32'($urandom_range(0, 20)) - 32'd10;
      3, 4, 5: return 32'(($signed({x[31], x}) + $signed({y[31], y})) >>> 1);
      6:       return ($urandom_range(0, 1)) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] draw_time();
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'($urandom_range(0, 400000));
      default: return $urandom();
    endcase
  endfunction

  // result side: random pop stalls, with stall-free stretches
  initial begin
    @(negedge clk);
    forever begin
      if (!pop_free) begin
        pop <= 1'b0;
        repeat (draw_gap()) @(negedge clk);
      end
      pop <= 1'b1;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: empty table, single entry with zero duration, then fill
    send_item(OP_EVAL, 8'd0, '0, '0, 32'h0001_2345, 32'h0);
    add_entry(8'd5, 31'd0, 32'h0);
    send_item(OP_EVAL, '0, '0, '0, 32'hFFFE_1234, 32'h0000_1000);
    send_item(OP_EVAL, '0, '0, '0, 32'h7FFF_FFFF, 32'h8000_0000);
    add_entry(8'd255, 31'h7FFF_FFFF, 32'h8000_0000);
    add_entry(8'd1, 31'd6, 32'h7FFF_FFFF);
    add_entry(8'd2, 31'd7, 32'h0);           // equal threshold: goes after
    add_entry(8'd3, 31'h0001_0000, 32'h0064_0000);
    add_entry(8'd4, 31'h0002_8000, 32'h0064_0004); // narrow pair
    add_entry(8'd6, 31'h4000_0000, 32'hFF00_0000);
    add_entry(8'd7, 31'h0000_0100, 32'h0000_8000);
    for (int k = 0; k < 9; k++)
      add_entry(8'($urandom()), 31'($urandom()), $urandom());
    send_item(OP_INSERT, 8'hAA, 31'h5555_5555, 32'h1234_5678, '0, '0); // dropped
    send_item(OP_EVAL, '0, '0, '0, 32'h8000_0000, 32'h8000_0000);
    send_item(OP_EVAL, '0, '0, '0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_item(OP_EVAL, '0, '0, '0, 32'h0003_0000, 32'h0064_0002);
    send_item(OP_EVAL, '0, '0, '0, 32'hFFFF_0000, 32'h0000_0000);
    send_item(OP_EVAL, '0, '0, '0, 32'h1234_5678, 32'h0032_0000);

    // random: mostly evaluates, dropped inserts as noise
    for (int n = 0; n < 1880; n++) begin
      idle_sender(draw_gap());
      if (n == 600) begin
        // hold off until every expected result is back
        push <= 1'b0;
        while (pending != 0) @(negedge clk);
      end
      pop_free = (n >= 1000 && n < 1200);
      if ($urandom_range(0, 9) == 0)
        send_item(OP_INSERT, 8'($urandom()), 31'($urandom()), $urandom(), $urandom(),
                  $urandom());
      else
        send_item(OP_EVAL, 8'($urandom()), 31'($urandom()), $urandom(), draw_time(),
                  aim_param());
    end
    push <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (400) @(negedge clk);
    if (failures == 0 && pending == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  initial begin
    #50_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

FILE: sim.f
rtl/bs1d_pkg.sv
rtl/bs1d_divider.sv
rtl/bs1d_front.sv
rtl/bs1d_back.sv
rtl/blend_space_1d_segment_weight_core.sv
bench/blend_space_1d_segment_weight_checker.sv
bench/tb_blend_space_1d_segment_weight_core.sv
